// ----- src/assert_macros.svh -----
// Assertion macros for the grid height traversability block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GHT_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GHT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- src/ght_pkg.sv -----
// Shared constants and types for the grid height traversability block.
package ght_pkg;

  localparam int CELLS_PER_SIDE_DEF = 4;
  localparam int COORD_WIDTH_DEF    = 24;

  localparam int REG_W     = 24;
  localparam int SIDE_W    = 20;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int INDEX_W   = 6;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIDE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT = 3'd4;

  localparam logic signed [REG_W-1:0] RST_GRID_LEFT    = 24'sd0;
  localparam logic signed [REG_W-1:0] RST_GRID_TOP     = 24'sd0;
  localparam logic [SIDE_W-1:0]       RST_CELL_SIDE    = 20'd256;
  localparam logic signed [REG_W-1:0] RST_HEIGHT_LIMIT = 24'sd512;
  localparam logic [REG_W-1:0]        RST_SPREAD_LIMIT = 24'd256;

  // per-cycle commands broadcast to every cell of the ring
  typedef struct packed {
    logic add;    // a point beat is in the update stage
    logic clr;    // empty the grid
    logic shift;  // rotate the ring by one cell toward the head
  } ght_ctl_t;

endpackage

// ----- src/grid_height_traversability_unit.sv -----
// Add/clear: one beat per cycle while the input is not stalled; a beat passes the
// stage-1 and stage-2 registers before it updates the cells. Evaluate: results come
// one per cycle while out_stall is low; input is stalled from the evaluate beat until
// the final cell is loaded out. A sweep covers all CELLS_PER_SIDE**2 cells, the ring
// rotating one cell per step. Reset (rst_n low, synchronous) clears occupied flags and
// control and loads register defaults, with no clearing pass.
`include "assert_macros.svh"

module grid_height_traversability_unit #(
  parameter int CELLS_PER_SIDE = ght_pkg::CELLS_PER_SIDE_DEF,
  parameter int COORD_WIDTH    = ght_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic signed [COORD_WIDTH-1:0]       in_point_x,
  input  logic signed [COORD_WIDTH-1:0]       in_point_y,
  input  logic signed [COORD_WIDTH-1:0]       in_point_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ght_pkg::INDEX_W-1:0]         out_cell_index,
  output logic                                out_empty_res,
  output logic                                out_drivable,
  output logic signed [COORD_WIDTH-1:0]       out_min_height,
  output logic signed [COORD_WIDTH-1:0]       out_max_height,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [ght_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ght_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int NUM_CELLS = CELLS_PER_SIDE * CELLS_PER_SIDE;
  localparam int CNT_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int MAXW      = (COORD_WIDTH > ght_pkg::REG_W) ? COORD_WIDTH : ght_pkg::REG_W;
  localparam int BW        = MAXW + 2;
  localparam int DW        = (COORD_WIDTH + 1 > ght_pkg::REG_W) ? COORD_WIDTH + 1
                                                                : ght_pkg::REG_W;
  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(NUM_CELLS - 1);

  // configuration
  logic signed [ght_pkg::REG_W-1:0]  grid_left_r, grid_top_r, height_limit_r;
  logic [ght_pkg::SIDE_W-1:0]        cell_side_r;
  logic [ght_pkg::REG_W-1:0]         spread_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_left_r    <= ght_pkg::RST_GRID_LEFT;
      grid_top_r     <= ght_pkg::RST_GRID_TOP;
      cell_side_r    <= ght_pkg::RST_CELL_SIDE;
      height_limit_r <= ght_pkg::RST_HEIGHT_LIMIT;
      spread_limit_r <= ght_pkg::RST_SPREAD_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ght_pkg::CFG_GRID_LEFT:    grid_left_r    <= signed'(cfg_wdata);
        ght_pkg::CFG_GRID_TOP:     grid_top_r     <= signed'(cfg_wdata);
        ght_pkg::CFG_CELL_SIDE:    cell_side_r    <= cfg_wdata[ght_pkg::SIDE_W-1:0];
        ght_pkg::CFG_HEIGHT_LIMIT: height_limit_r <= signed'(cfg_wdata);
        ght_pkg::CFG_SPREAD_LIMIT: spread_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // column and row bounds, recomputed every cycle from the registers
  logic signed [BW-1:0] side_s, left_s, top_s;
  logic signed [BW-1:0] col_lo_r [CELLS_PER_SIDE];
  logic signed [BW-1:0] col_hi_r [CELLS_PER_SIDE];
  logic signed [BW-1:0] row_lo_r [CELLS_PER_SIDE];
  logic signed [BW-1:0] row_hi_r [CELLS_PER_SIDE];

  assign side_s = BW'(signed'({1'b0, cell_side_r}));
  assign left_s = BW'(grid_left_r);
  assign top_s  = BW'(grid_top_r);

  // stage 1: accepted beat
  logic                          s1_valid_r;
  logic [1:0]                    s1_op_r;
  logic signed [COORD_WIDTH-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic signed [BW-1:0]          s1_x_s, s1_y_s;
  logic [CELLS_PER_SIDE-1:0]     col_hit, row_hit;

  // stage 2: cell select and update
  logic                          s2_valid_r;
  logic [1:0]                    s2_op_r;
  logic signed [COORD_WIDTH-1:0] s2_z_r;
  logic [CELLS_PER_SIDE-1:0]     col_hit_r, row_hit_r;

  logic in_acc, s1_eval, s2_eval;
  logic sweep_r, step;
  logic [CNT_W-1:0] cnt_r;

  assign s1_x_s = BW'(s1_x_r);
  assign s1_y_s = BW'(s1_y_r);

  // boundaries are exclusive: a point on an edge hits nothing
  for (genvar c = 0; c < CELLS_PER_SIDE; c++) begin : g_bounds
    always_ff @(posedge clk) begin
      col_lo_r[c] <= left_s + side_s * BW'(c);
      col_hi_r[c] <= left_s + side_s * BW'(c + 1);
      row_hi_r[c] <= top_s - side_s * BW'(c);
      row_lo_r[c] <= top_s - side_s * BW'(c + 1);
    end
    assign col_hit[c] = (s1_x_s > col_lo_r[c]) && (s1_x_s < col_hi_r[c]);
    assign row_hit[c] = (s1_y_s > row_lo_r[c]) && (s1_y_s < row_hi_r[c]);
  end

  assign s1_eval  = s1_valid_r && (s1_op_r == ght_pkg::OP_EVAL);
  assign s2_eval  = s2_valid_r && (s2_op_r == ght_pkg::OP_EVAL);
  assign in_stall = s1_eval || s2_eval || sweep_r;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= in_op;
      s1_x_r  <= in_point_x;
      s1_y_r  <= in_point_y;
      s1_z_r  <= in_point_z;
    end
    s2_op_r   <= s1_op_r;
    s2_z_r    <= s1_z_r;
    col_hit_r <= col_hit;
    row_hit_r <= row_hit;
  end

  // cell ring: position 0 is the head, the ring rotates toward it during a sweep
  ght_pkg::ght_ctl_t ctl;
  logic                          occ_w [NUM_CELLS];
  logic signed [COORD_WIDTH-1:0] lo_w  [NUM_CELLS];
  logic signed [COORD_WIDTH-1:0] hi_w  [NUM_CELLS];

  assign ctl.add   = s2_valid_r && (s2_op_r == ght_pkg::OP_ADD);
  assign ctl.clr   = s2_valid_r && (s2_op_r == ght_pkg::OP_CLEAR);
  assign ctl.shift = step;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ght_cell #(
      .W (COORD_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .hit     (col_hit_r[k / CELLS_PER_SIDE] && row_hit_r[k % CELLS_PER_SIDE]),
      .z       (s2_z_r),
      .nbr_occ (occ_w[(k + 1) % NUM_CELLS]),
      .nbr_lo  (lo_w[(k + 1) % NUM_CELLS]),
      .nbr_hi  (hi_w[(k + 1) % NUM_CELLS]),
      .occ     (occ_w[k]),
      .lo      (lo_w[k]),
      .hi      (hi_w[k])
    );
  end

  // sweep control
  logic out_valid_r;

  assign step = sweep_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_eval) begin
        sweep_r <= 1'b1;
      end else if (step) begin
        if (cnt_r == LAST_CELL) begin
          sweep_r <= 1'b0;
          cnt_r   <= '0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // head cell evaluation
  logic signed [MAXW-1:0]        head_hi_x, hlim_x;
  logic signed [COORD_WIDTH:0]   spread_w;
  logic                          head_drv;

  assign head_hi_x = MAXW'(hi_w[0]);
  assign hlim_x    = MAXW'(height_limit_r);
  assign spread_w  = (COORD_WIDTH + 1)'(hi_w[0]) - (COORD_WIDTH + 1)'(lo_w[0]);
  assign head_drv  = occ_w[0] && (head_hi_x <= hlim_x) &&
                     (DW'(unsigned'(spread_w)) <= DW'(spread_limit_r));

  logic [ght_pkg::INDEX_W-1:0]   out_cell_index_r;
  logic                          out_empty_res_r, out_drivable_r, out_last_r;
  logic signed [COORD_WIDTH-1:0] out_min_height_r, out_max_height_r;

  always_ff @(posedge clk) begin
    if (step) begin
      out_cell_index_r <= ght_pkg::INDEX_W'(cnt_r);
      out_empty_res_r  <= !occ_w[0];
      out_drivable_r   <= head_drv;
      out_min_height_r <= occ_w[0] ? lo_w[0] : '0;
      out_max_height_r <= occ_w[0] ? hi_w[0] : '0;
      out_last_r       <= (cnt_r == LAST_CELL);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_index = out_cell_index_r;
  assign out_empty_res  = out_empty_res_r;
  assign out_drivable   = out_drivable_r;
  assign out_min_height = out_min_height_r;
  assign out_max_height = out_max_height_r;
  assign out_last       = out_last_r;

  `GHT_ASSERT_NEXT(a_eval_blocks_input, in_valid && !in_stall && in_op == ght_pkg::OP_EVAL, in_stall, "input not stalled behind evaluate beat")
  `GHT_ASSERT_IMPL(a_cnt_idle_zero, !sweep_r, cnt_r == '0, "sweep counter not parked at zero")
  `GHT_ASSERT_IMPL(a_last_on_final_cell, out_valid && out_last, out_cell_index == ght_pkg::INDEX_W'(NUM_CELLS - 1), "last flag on wrong cell")
  `GHT_ASSERT_NEXT(a_step_loads_output, step, out_valid, "ring step without output beat")

endmodule

// ----- src/ght_cell.sv -----
// One grid cell: occupied flag and height range, part of a rotating ring.
module ght_cell #(
  parameter int W = ght_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ght_pkg::ght_ctl_t   ctl,
  input  logic                hit,
  input  logic signed [W-1:0] z,
  input  logic                nbr_occ,
  input  logic signed [W-1:0] nbr_lo,
  input  logic signed [W-1:0] nbr_hi,
  output logic                occ,
  output logic signed [W-1:0] lo,
  output logic signed [W-1:0] hi
);

  logic                occ_r, occ_nxt;
  logic signed [W-1:0] lo_r, lo_nxt;
  logic signed [W-1:0] hi_r, hi_nxt;

  always_comb begin
    occ_nxt = occ_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    priority if (ctl.shift) begin
      occ_nxt = nbr_occ;
      lo_nxt  = nbr_lo;
      hi_nxt  = nbr_hi;
    end else if (ctl.clr) begin
      occ_nxt = 1'b0;
    end else if (ctl.add && hit) begin
      if (!occ_r) begin
        occ_nxt = 1'b1;
        lo_nxt  = z;
        hi_nxt  = z;
      end else begin
        if (z < lo_r) lo_nxt = z;
        if (z > hi_r) hi_nxt = z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // heights are only read behind a set occupied flag
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign occ = occ_r;
  assign lo  = lo_r;
  assign hi  = hi_r;

endmodule
